// ===== rtl/tlbpt_pkg.sv =====
// Shared types and constants for the TLB and page table translator.
package tlbpt_pkg;

  localparam int ADDR_W     = 16;
  localparam int PAGE_W     = 8;
  localparam int PHYS_W     = 14;
  localparam int CNT_W      = 32;
  localparam int GROUP_SIZE = 16;

  typedef struct packed {
    logic capture;
    logic reduce;
    logic commit;
  } tlbpt_cmd_t;

endpackage

// ===== rtl/tlbpt_ctrl.sv =====
// Controller state machine: sequences capture, reduce and commit, owns the handshakes.
module tlbpt_ctrl
  import tlbpt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output tlbpt_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.reduce  = (state_q == S_RED);
  assign cmd_o.commit  = (state_q == S_UPD) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) state_d = S_RED;
      end
      S_RED: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (cmd_o.commit) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == S_RED) ##1 (state_q == S_UPD))
    else $error("capture did not advance to reduce and commit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) && out_valid_q && !out_ready_i |=> (state_q == S_UPD))
    else $error("commit overran a pending word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q && (state_q == S_IDLE))
    else $error("commit did not load the output word");

endmodule

// ===== rtl/tlbpt_datapath.sv =====
// Datapath: TLB and page table storage, parallel match, reduction tree, counters, output word.
module tlbpt_datapath
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = 128,
  parameter int FRAME_COUNT = 64,
  parameter int OFFSET_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tlbpt_cmd_t        cmd_i,
  input  logic [ADDR_W-1:0] virt_addr_i,
  output logic [PHYS_W-1:0] phys_addr_o,
  output logic              tlb_hit_o,
  output logic              page_fault_o,
  output logic [CNT_W-1:0]  hit_total_o,
  output logic [CNT_W-1:0]  fault_total_o
);

  localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
  localparam int FRAME_W   = $clog2(FRAME_COUNT);
  localparam int TLB_GRP   = (TLB_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int TBL_GRP   = (FRAME_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int FULL_W    = FRAME_W + OFFSET_BITS;

  logic [PAGE_W-1:0]      tlb_tag_q   [TLB_ENTRIES];
  logic [FRAME_W-1:0]     tlb_frame_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid_q;
  logic [TLB_IDX_W-1:0]   fill_ptr_q;
  logic [PAGE_W-1:0]      tbl_page_q  [FRAME_COUNT];
  logic [FRAME_COUNT-1:0] tbl_valid_q;
  logic [FRAME_W-1:0]     next_frame_q;
  logic [CNT_W-1:0]       hit_cnt_q, hit_cnt_d;
  logic [CNT_W-1:0]       fault_cnt_q, fault_cnt_d;

  logic [PAGE_W-1:0]      page_q;
  logic [OFFSET_BITS-1:0] offset_q;
  logic [TLB_ENTRIES-1:0] tlb_match_q, tlb_match_d;
  logic [FRAME_COUNT-1:0] tbl_match_q, tbl_match_d;

  logic [FRAME_W-1:0]     tlb_part_q [TLB_GRP];
  logic [FRAME_W-1:0]     tlb_part_d [TLB_GRP];
  logic [TLB_GRP-1:0]     tlb_ghit_q, tlb_ghit_d;
  logic [FRAME_W-1:0]     tbl_part_q [TBL_GRP];
  logic [FRAME_W-1:0]     tbl_part_d [TBL_GRP];
  logic [TBL_GRP-1:0]     tbl_ghit_q, tbl_ghit_d;

  logic [PHYS_W-1:0]      phys_q;
  logic                   hit_q, fault_q;
  logic [CNT_W-1:0]       hit_tot_q, fault_tot_q;

  logic [ADDR_W-1:0]      addr_shift;
  logic [PAGE_W-1:0]      in_page;
  logic                   hit, tbl_hit, fault;
  logic [FRAME_W-1:0]     tlb_frame, tbl_frame, frame;
  logic [FULL_W+PHYS_W-1:0] phys_ext;

  assign addr_shift = virt_addr_i >> OFFSET_BITS;
  assign in_page    = addr_shift[PAGE_W-1:0];

  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      tlb_match_d[i] = tlb_valid_q[i] && (tlb_tag_q[i] == in_page);
    end
    for (int i = 0; i < FRAME_COUNT; i++) begin
      tbl_match_d[i] = tbl_valid_q[i] && (tbl_page_q[i] == in_page);
    end
  end

  always_comb begin
    for (int g = 0; g < TLB_GRP; g++) begin
      tlb_part_d[g] = '0;
      tlb_ghit_d[g] = 1'b0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < TLB_ENTRIES) begin
          if (tlb_match_q[g * GROUP_SIZE + k]) begin
            tlb_part_d[g] = tlb_part_d[g] | tlb_frame_q[g * GROUP_SIZE + k];
            tlb_ghit_d[g] = 1'b1;
          end
        end
      end
    end
    for (int g = 0; g < TBL_GRP; g++) begin
      tbl_part_d[g] = '0;
      tbl_ghit_d[g] = 1'b0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < FRAME_COUNT) begin
          if (tbl_match_q[g * GROUP_SIZE + k]) begin
            tbl_part_d[g] = tbl_part_d[g] | FRAME_W'(g * GROUP_SIZE + k);
            tbl_ghit_d[g] = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    tlb_frame = '0;
    tbl_frame = '0;
    for (int g = 0; g < TLB_GRP; g++) begin
      tlb_frame = tlb_frame | tlb_part_q[g];
    end
    for (int g = 0; g < TBL_GRP; g++) begin
      tbl_frame = tbl_frame | tbl_part_q[g];
    end
    hit     = |tlb_ghit_q;
    tbl_hit = |tbl_ghit_q;
    fault   = !hit && !tbl_hit;
    if (hit) begin
      frame = tlb_frame;
    end else if (tbl_hit) begin
      frame = tbl_frame;
    end else begin
      frame = next_frame_q;
    end
    phys_ext    = {PHYS_W'(0), frame, offset_q};
    hit_cnt_d   = hit_cnt_q + CNT_W'(hit);
    fault_cnt_d = fault_cnt_q + CNT_W'(fault);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_valid_q  <= '0;
      fill_ptr_q   <= '0;
      tbl_valid_q  <= '0;
      next_frame_q <= '0;
      hit_cnt_q    <= '0;
      fault_cnt_q  <= '0;
      tlb_match_q  <= '0;
      tbl_match_q  <= '0;
      tlb_ghit_q   <= '0;
      tbl_ghit_q   <= '0;
    end else begin
      if (cmd_i.capture) begin
        tlb_match_q <= tlb_match_d;
        tbl_match_q <= tbl_match_d;
      end
      if (cmd_i.reduce) begin
        tlb_ghit_q <= tlb_ghit_d;
        tbl_ghit_q <= tbl_ghit_d;
      end
      if (cmd_i.commit) begin
        hit_cnt_q   <= hit_cnt_d;
        fault_cnt_q <= fault_cnt_d;
        if (!hit) begin
          tlb_valid_q[fill_ptr_q] <= 1'b1;
          fill_ptr_q <= (fill_ptr_q == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0 : fill_ptr_q + 1'b1;
        end
        if (fault) begin
          tbl_valid_q[next_frame_q] <= 1'b1;
          next_frame_q <= (next_frame_q == FRAME_W'(FRAME_COUNT - 1)) ?
                          '0 : next_frame_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q   <= in_page;
      offset_q <= virt_addr_i[OFFSET_BITS-1:0];
    end
    if (cmd_i.reduce) begin
      tlb_part_q <= tlb_part_d;
      tbl_part_q <= tbl_part_d;
    end
    if (cmd_i.commit) begin
      if (!hit) begin
        tlb_tag_q[fill_ptr_q]   <= page_q;
        tlb_frame_q[fill_ptr_q] <= frame;
      end
      if (fault) begin
        tbl_page_q[next_frame_q] <= page_q;
      end
      phys_q      <= phys_ext[PHYS_W-1:0];
      hit_q       <= hit;
      fault_q     <= fault;
      hit_tot_q   <= hit_cnt_d;
      fault_tot_q <= fault_cnt_d;
    end
  end

  assign phys_addr_o   = phys_q;
  assign tlb_hit_o     = hit_q;
  assign page_fault_o  = fault_q;
  assign hit_total_o   = hit_tot_q;
  assign fault_total_o = fault_tot_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tlb_match_q))
    else $error("page mapped by more than one valid TLB entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tbl_match_q))
    else $error("page held in more than one page table slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && hit |=> hit_cnt_q == $past(hit_cnt_q) + CNT_W'(1))
    else $error("hit count did not advance on a TLB hit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> !(hit_q && fault_q))
    else $error("word flagged as both hit and fault");

endmodule

// ===== rtl/tlb_page_table_translator.sv =====
// Top level: TLB and page table address translator.
// A word passes from acceptance to its result through capture, reduce and commit: capture
// registers the parallel tag match of all TLB entries and page table slots, reduce registers
// an OR tree over groups of sixteen, and commit performs the TLB fill, page table update,
// counters and result word. A new word is accepted the cycle after commit, so a word is
// taken only once the previous one has committed; commit waits while the output register
// still holds an untaken word. No clearing pass follows reset.
module tlb_page_table_translator
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = 128,
  parameter int FRAME_COUNT = 64,
  parameter int OFFSET_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ADDR_W-1:0] virt_addr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PHYS_W-1:0] phys_addr_o,
  output logic              tlb_hit_o,
  output logic              page_fault_o,
  output logic [CNT_W-1:0]  hit_total_o,
  output logic [CNT_W-1:0]  fault_total_o
);

  tlbpt_cmd_t cmd;

  tlbpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .FRAME_COUNT (FRAME_COUNT),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .virt_addr_i   (virt_addr_i),
    .phys_addr_o   (phys_addr_o),
    .tlb_hit_o     (tlb_hit_o),
    .page_fault_o  (page_fault_o),
    .hit_total_o   (hit_total_o),
    .fault_total_o (fault_total_o)
  );

endmodule

// ===== tb/sv/tlbpt_checker.sv =====
// Checker for the TLB and page table translator: predicts each translation and compares results.
module tlbpt_checker
  import tlbpt_pkg::*;
#(
  parameter int TLB_ENTRIES = 128,
  parameter int FRAME_COUNT = 64,
  parameter int OFFSET_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [ADDR_W-1:0] virt_addr_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [PHYS_W-1:0] phys_addr_i,
  input  logic              tlb_hit_i,
  input  logic              page_fault_i,
  input  logic [CNT_W-1:0]  hit_total_i,
  input  logic [CNT_W-1:0]  fault_total_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o,
  output int                stale_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int SLOT_W  = $clog2(TLB_ENTRIES);

  typedef struct packed {
    logic [PHYS_W-1:0] phys_addr;
    logic              tlb_hit;
    logic              page_fault;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  fault_total;
  } xlat_t;

  logic [PAGE_W-1:0]  tlb_tag    [TLB_ENTRIES];
  logic [FRAME_W-1:0] tlb_frame  [TLB_ENTRIES];
  logic               tlb_valid  [TLB_ENTRIES];
  logic [SLOT_W-1:0]  fill_ptr;
  logic [PAGE_W-1:0]  table_page [FRAME_COUNT];
  logic               table_valid[FRAME_COUNT];
  logic [FRAME_W-1:0] next_frame;
  logic [CNT_W-1:0]   hit_count;
  logic [CNT_W-1:0]   fault_count;

  xlat_t expected_xlat[$];
  xlat_t want;
  int    errors;
  int    checked;
  int    stale_hits;

  function automatic xlat_t translate(input logic [ADDR_W-1:0] addr);
    logic [PAGE_W-1:0]  page;
    int unsigned        offset;
    logic [FRAME_W-1:0] frame;
    logic               found;
    xlat_t              r;
    page   = PAGE_W'((addr >> OFFSET_BITS) & 16'h00FF);
    offset = addr & ((1 << OFFSET_BITS) - 1);
    frame  = '0;
    found  = 1'b0;
    r      = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!found && tlb_valid[i] && tlb_tag[i] == page) begin
        found = 1'b1;
        frame = tlb_frame[i];
      end
    end
    if (found) begin
      r.tlb_hit = 1'b1;
      hit_count++;
      if (!(table_valid[frame] && table_page[frame] == page)) begin
        stale_hits++;
      end
    end else begin
      for (int j = 0; j < FRAME_COUNT; j++) begin
        if (!found && table_valid[j] && table_page[j] == page) begin
          found = 1'b1;
          frame = FRAME_W'(j);
        end
      end
      if (!found) begin
        r.page_fault = 1'b1;
        frame = next_frame;
        next_frame = (next_frame == FRAME_W'(FRAME_COUNT - 1)) ? '0 : next_frame + 1'b1;
        table_page[frame]  = page;
        table_valid[frame] = 1'b1;
        fault_count++;
      end
      tlb_tag[fill_ptr]   = page;
      tlb_frame[fill_ptr] = frame;
      tlb_valid[fill_ptr] = 1'b1;
      fill_ptr = (fill_ptr == SLOT_W'(TLB_ENTRIES - 1)) ? '0 : fill_ptr + 1'b1;
    end
    r.phys_addr   = PHYS_W'((int'(frame) << OFFSET_BITS) | offset);
    r.hit_total   = hit_count;
    r.fault_total = fault_count;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] exp_val,
                                      input logic [CNT_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TLB_ENTRIES; i++) tlb_valid[i] = 1'b0;
      for (int j = 0; j < FRAME_COUNT; j++) table_valid[j] = 1'b0;
      fill_ptr    = '0;
      next_frame  = '0;
      hit_count   = '0;
      fault_count = '0;
      expected_xlat.delete();
      errors      = 0;
      checked     = 0;
      stale_hits  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_xlat.size() == 0) begin
          $display("%0t: unexpected word: expected none, got phys_addr %0h", $time,
                   phys_addr_i);
          errors++;
        end else begin
          want = expected_xlat.pop_front();
          check_field("phys_addr", CNT_W'(want.phys_addr), CNT_W'(phys_addr_i));
          check_field("tlb_hit", CNT_W'(want.tlb_hit), CNT_W'(tlb_hit_i));
          check_field("page_fault", CNT_W'(want.page_fault), CNT_W'(page_fault_i));
          check_field("hit_total", want.hit_total, hit_total_i);
          check_field("fault_total", want.fault_total, fault_total_i);
          checked++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_xlat.push_back(translate(virt_addr_i));
      end
    end
    fail_count_o <= errors;
    pending_o    <= expected_xlat.size();
    checked_o    <= checked;
    stale_hits_o <= stale_hits;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the TLB and page table translator: clock, reset, stimulus and verdict.
module tb_top;
  import tlbpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 300;

  logic              clk_i       = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [ADDR_W-1:0] virt_addr   = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [PHYS_W-1:0] phys_addr;
  logic              tlb_hit;
  logic              page_fault;
  logic [CNT_W-1:0]  hit_total;
  logic [CNT_W-1:0]  fault_total;

  int   fail_count;
  int   pending;
  int   checked;
  int   stale_hits;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic stall_req   = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_left   = 0;
  int   cycles      = 0;

  tlb_page_table_translator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .virt_addr_i  (virt_addr),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .phys_addr_o  (phys_addr),
    .tlb_hit_o    (tlb_hit),
    .page_fault_o (page_fault),
    .hit_total_o  (hit_total),
    .fault_total_o(fault_total)
  );

  tlbpt_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .virt_addr_i  (virt_addr),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .phys_addr_i  (phys_addr),
    .tlb_hit_i    (tlb_hit),
    .page_fault_i (page_fault),
    .hit_total_i  (hit_total),
    .fault_total_i(fault_total),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .stale_hits_o (stale_hits)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tlb_page_table_translator test failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (stall_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_word(input logic [ADDR_W-1:0] addr);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid  <= 1'b1;
    virt_addr <= addr;
    do @(posedge clk_i); while (!in_ready);
  endtask

  initial begin
    logic [ADDR_W-1:0] corner_addrs[] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h00FF,
                                          16'hFF00, 16'hFFFF, 16'h8000, 16'h7FFF,
                                          16'h0100, 16'h01AA, 16'hAA55, 16'h55AA,
                                          16'h8000, 16'h0001, 16'hFE80};
    logic [PAGE_W-1:0] hot_pages[8];
    logic [PAGE_W-1:0] page;
    int                pick;

    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (corner_addrs[k]) send_word(corner_addrs[k]);

    foreach (hot_pages[h]) hot_pages[h] = PAGE_W'($urandom);
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct <= (ph == 0) ? 10 : (ph == 1) ? 56 : 0;
      rx_idle_pct <= (ph == 0) ? 56 : (ph == 1) ? 10 : 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 2 && n == 20) stall_req <= 1'b1;
        pick = $urandom_range(99);
        if (pick < 10) hot_pages[3'($urandom_range(7))] = PAGE_W'($urandom);
        if (pick < 62) page = hot_pages[3'($urandom_range(7))];
        else page = PAGE_W'($urandom);
        send_word({page, 8'($urandom)});
      end
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d translations over three idle mixes and one long output hold;",
             checked);
    $display("TLB hits %0d, page faults %0d, hits through stale entries %0d.",
             u_checker.hit_count, u_checker.fault_count, stale_hits);
    if (pending != 0) $display("%0d translations never came out", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tlb_page_table_translator test passed");
    end else begin
      $display("tlb_page_table_translator test failed");
    end
    $finish;
  end

endmodule

// ===== tlb_page_table_translator.f =====
rtl/tlbpt_pkg.sv
rtl/tlbpt_ctrl.sv
rtl/tlbpt_datapath.sv
rtl/tlb_page_table_translator.sv
tb/sv/tlbpt_checker.sv
tb/sv/tb_top.sv
